/* design/polygon_face_normal_core_macros.svh */
// ----------------------------------------------------------------------------
// polygon face normal core assertion macros
// Shared concurrent assertion forms for the design files.
// ----------------------------------------------------------------------------
`ifndef POLYGON_FACE_NORMAL_CORE_MACROS_SVH
`define POLYGON_FACE_NORMAL_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PFN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pfn_pkg.sv */
// ----------------------------------------------------------------------------
// pfn_pkg
// Types and constants shared by the polygon face normal core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfn_pkg;

  localparam logic [15:0] MaxPolyVertices = 16'd65535;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic               has_tri;
    logic               last;
    logic signed [32:0] a_x;
    logic signed [32:0] a_y;
    logic signed [32:0] a_z;
    logic signed [32:0] b_x;
    logic signed [32:0] b_y;
    logic signed [32:0] b_z;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

/* design/pfn_front.sv */
// ----------------------------------------------------------------------------
// pfn_front
// Accepts vertices, tracks first and previous point, issues triangle jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module pfn_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic                last_vertex,
  input  wire pfn_pkg::queue_stat_t qstat,
  output logic                     job_push,
  output pfn_pkg::job_t            job
);

  logic [15:0]        vertex_count;
  logic signed [31:0] first_x, first_y, first_z;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic               accept;
  logic               room;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign room     = vertex_count < pfn_pkg::MaxPolyVertices;

  // fan triangle edge vectors relative to the first point
  always_comb begin
    job.has_tri = room && (vertex_count >= 16'd2);
    job.last    = last_vertex;
    job.a_x     = {prev_x[31], prev_x} - {first_x[31], first_x};
    job.a_y     = {prev_y[31], prev_y} - {first_y[31], first_y};
    job.a_z     = {prev_z[31], prev_z} - {first_z[31], first_z};
    job.b_x     = {pos_x[31], pos_x} - {first_x[31], first_x};
    job.b_y     = {pos_y[31], pos_y} - {first_y[31], first_y};
    job.b_z     = {pos_z[31], pos_z} - {first_z[31], first_z};
    job_push    = accept && (job.has_tri || last_vertex);
  end

  // vertex counter
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (accept) begin
      if (last_vertex) begin
        vertex_count <= '0;
      end else if (room) begin
        vertex_count <= vertex_count + 16'd1;
      end
    end
  end

  // first and previous point
  always_ff @(posedge clk) begin
    if (accept && room) begin
      if (vertex_count == 16'd0) begin
        first_x <= pos_x;
        first_y <= pos_y;
        first_z <= pos_z;
      end
      prev_x <= pos_x;
      prev_y <= pos_y;
      prev_z <= pos_z;
    end
  end

endmodule

`default_nettype wire

/* design/pfn_queue.sv */
// ----------------------------------------------------------------------------
// pfn_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfn_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire pfn_pkg::job_t        push_job,
  input  wire logic                 pop,
  output pfn_pkg::job_t             head,
  output pfn_pkg::queue_stat_t      qstat
);

  pfn_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign head        = slots[rd_ptr];
  assign qstat.full  = fill == 2'd2;
  assign qstat.empty = fill == 2'd0;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* design/pfn_back.sv */
// ----------------------------------------------------------------------------
// pfn_back
// Sequential unit: cross product, unit scaling, accumulation, averaging.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_face_normal_core_macros.svh"

module pfn_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pfn_pkg::queue_stat_t qstat,
  input  wire pfn_pkg::job_t        head,
  output logic                      job_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        norm_x,
  output logic signed [31:0]        norm_y,
  output logic signed [31:0]        norm_z,
  output logic                      too_few_vertices
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_CROSS, ST_CMAG, ST_CLEN, ST_CSHIFT, ST_SQ, ST_SQRT,
    ST_DIV_LOAD, ST_DIV, ST_ACC, ST_COUNT, ST_FIN_START, ST_FIN_LOAD, ST_FIN_DIV,
    ST_OUT
  } state_t;

  state_t             state;
  pfn_pkg::job_t      job_r;
  logic [5:0]         step;
  logic [1:0]         comp;
  logic signed [30:0] d [6];
  logic signed [62:0] c [3];
  logic [61:0]        cm [3];
  logic               cneg [3];
  logic [5:0]         clen;
  logic [30:0]        norm [3];
  logic [63:0]        sq;
  logic [63:0]        work;
  logic [33:0]        srem;
  logic [31:0]        root;
  logic [32:0]        drem;
  logic [30:0]        dnum;
  logic [30:0]        quo;
  logic signed [47:0] sum [3];
  logic [15:0]        tcount;
  logic [47:0]        fnum;
  logic [16:0]        frem;
  logic               fneg;
  logic signed [31:0] res [3];
  logic               res_flag;
  logic               result_load;

  // highest set bit position plus one
  function automatic logic [5:0] bit_len62(input logic [61:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 62; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

  // difference magnitudes and common scaling
  logic [32:0] dm [6];
  logic [32:0] dm_or;
  logic [5:0]  dlen;
  logic [5:0]  dsh;
  always_comb begin
    dm[0] = job_r.a_x[32] ? 33'(-job_r.a_x) : job_r.a_x;
    dm[1] = job_r.a_y[32] ? 33'(-job_r.a_y) : job_r.a_y;
    dm[2] = job_r.a_z[32] ? 33'(-job_r.a_z) : job_r.a_z;
    dm[3] = job_r.b_x[32] ? 33'(-job_r.b_x) : job_r.b_x;
    dm[4] = job_r.b_y[32] ? 33'(-job_r.b_y) : job_r.b_y;
    dm[5] = job_r.b_z[32] ? 33'(-job_r.b_z) : job_r.b_z;
    dm_or = dm[0] | dm[1] | dm[2] | dm[3] | dm[4] | dm[5];
    dlen  = bit_len62({29'b0, dm_or});
    dsh   = (dlen > 6'd30) ? dlen - 6'd30 : 6'd0;
  end

  logic [5:0] dneg;
  assign dneg = {job_r.b_z[32], job_r.b_y[32], job_r.b_x[32],
                 job_r.a_z[32], job_r.a_y[32], job_r.a_x[32]};

  // shared multiplier operand selection for the cross product
  logic signed [30:0] op_a, op_b;
  logic signed [61:0] prod;
  always_comb begin
    unique case (step[2:0])
      3'd0:    begin op_a = d[1]; op_b = d[5]; end
      3'd1:    begin op_a = d[2]; op_b = d[4]; end
      3'd2:    begin op_a = d[2]; op_b = d[3]; end
      3'd3:    begin op_a = d[0]; op_b = d[5]; end
      3'd4:    begin op_a = d[0]; op_b = d[4]; end
      3'd5:    begin op_a = d[1]; op_b = d[3]; end
      default: begin op_a = '0;   op_b = '0;   end
    endcase
    prod = op_a * op_b;
  end

  // unsigned square for the length
  logic [61:0] sqr;
  assign sqr = norm[comp] * norm[comp];

  // square root step
  logic [35:0] s_shift;
  logic [35:0] s_trial;
  assign s_shift = {srem, work[63:62]};
  assign s_trial = {2'b00, root, 2'b01};

  // unit division step
  logic [33:0] d_shift;
  assign d_shift = {drem, dnum[30]};

  // averaging division step
  logic [16:0] f_shift;
  assign f_shift = {frem[15:0], fnum[47]};

  // final quotient including the last step's bit
  logic [47:0] fq;
  assign fq = {fnum[46:0], (f_shift >= {1'b0, tcount})};

  // clamped unit component
  logic [30:0] unit;
  assign unit = (quo > pfn_pkg::OneQ30) ? pfn_pkg::OneQ30 : quo;

  logic [30:0] norm_or;
  assign norm_or = norm[0] | norm[1] | norm[2];

  logic [61:0] cm_or;
  assign cm_or = cm[0] | cm[1] | cm[2];

  assign job_pop     = (state == ST_IDLE) && !qstat.empty;
  assign result_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      tcount    <= '0;
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && !result_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_pop) begin
            job_r <= head;
            state <= head.has_tri ? ST_SCALE : ST_FIN_START;
          end
        end
        ST_SCALE: begin
          for (int i = 0; i < 6; i++) begin
            d[i] <= dneg[i] ? -$signed(31'(dm[i] >> dsh)) : $signed(31'(dm[i] >> dsh));
          end
          step  <= '0;
          state <= ST_CROSS;
        end
        ST_CROSS: begin
          if (step[0]) begin
            c[step[2:1]] <= c[step[2:1]] - 63'(prod);
          end else begin
            c[step[2:1]] <= 63'(prod);
          end
          step <= step + 6'd1;
          if (step == 6'd5) begin
            state <= ST_CMAG;
          end
        end
        ST_CMAG: begin
          for (int i = 0; i < 3; i++) begin
            cneg[i] <= c[i][62];
            cm[i]   <= c[i][62] ? 62'(-c[i]) : 62'(c[i]);
          end
          state <= ST_CLEN;
        end
        ST_CLEN: begin
          clen  <= bit_len62(cm_or);
          state <= (cm_or == '0) ? ST_COUNT : ST_CSHIFT;
        end
        ST_CSHIFT: begin
          for (int i = 0; i < 3; i++) begin
            if (clen > 6'd31) begin
              norm[i] <= 31'(cm[i] >> (clen - 6'd31));
            end else begin
              norm[i] <= 31'(cm[i] << (6'd31 - clen));
            end
          end
          comp  <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (comp == 2'd0) begin
            sq <= {2'b00, sqr};
          end else begin
            sq <= sq + {2'b00, sqr};
          end
          if (comp == 2'd2) begin
            work  <= sq + {2'b00, sqr};
            srem  <= '0;
            root  <= '0;
            step  <= '0;
            state <= ST_SQRT;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        ST_SQRT: begin
          work <= {work[61:0], 2'b00};
          if (s_shift >= s_trial) begin
            srem <= 34'(s_shift - s_trial);
            root <= {root[30:0], 1'b1};
          end else begin
            srem <= s_shift[33:0];
            root <= {root[30:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd31) begin
            comp  <= '0;
            state <= ST_DIV_LOAD;
          end
        end
        ST_DIV_LOAD: begin
          drem  <= {3'b000, norm[comp][30:1]};
          dnum  <= {norm[comp][0], 30'b0};
          quo   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          dnum <= {dnum[29:0], 1'b0};
          if (d_shift >= {2'b00, root}) begin
            drem <= 33'(d_shift - {2'b00, root});
            quo  <= {quo[29:0], 1'b1};
          end else begin
            drem <= d_shift[32:0];
            quo  <= {quo[29:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd30) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (cneg[comp]) begin
            sum[comp] <= sum[comp] - $signed({17'b0, unit});
          end else begin
            sum[comp] <= sum[comp] + $signed({17'b0, unit});
          end
          if (comp == 2'd2) begin
            state <= ST_COUNT;
          end else begin
            comp  <= comp + 2'd1;
            state <= ST_DIV_LOAD;
          end
        end
        ST_COUNT: begin
          tcount <= tcount + 16'd1;
          state  <= job_r.last ? ST_FIN_START : ST_IDLE;
        end
        ST_FIN_START: begin
          comp <= '0;
          if (tcount == 16'd0) begin
            for (int i = 0; i < 3; i++) begin
              res[i] <= '0;
            end
            res_flag <= 1'b1;
            state    <= ST_OUT;
          end else begin
            res_flag <= 1'b0;
            state    <= ST_FIN_LOAD;
          end
        end
        ST_FIN_LOAD: begin
          fneg  <= sum[comp][47];
          fnum  <= sum[comp][47] ? 48'(-sum[comp]) : 48'(sum[comp]);
          frem  <= '0;
          step  <= '0;
          state <= ST_FIN_DIV;
        end
        ST_FIN_DIV: begin
          if (f_shift >= {1'b0, tcount}) begin
            frem <= f_shift - {1'b0, tcount};
            fnum <= {fnum[46:0], 1'b1};
          end else begin
            frem <= f_shift;
            fnum <= {fnum[46:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd47) begin
            // store the averaged component, then the next one or the output
            res[comp] <= fneg ? -$signed(fq[31:0]) : $signed(fq[31:0]);
            if (comp == 2'd2) begin
              state <= ST_OUT;
            end else begin
              comp  <= comp + 2'd1;
              state <= ST_FIN_LOAD;
            end
          end
        end
        ST_OUT: begin
          if (result_load) begin
            norm_x           <= res[0];
            norm_y           <= res[1];
            norm_z           <= res[2];
            too_few_vertices <= res_flag;
            out_valid        <= 1'b1;
            tcount           <= '0;
            for (int i = 0; i < 3; i++) begin
              sum[i] <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PFN_ASSERT_SAME(a_norm_range, state == ST_SQ, norm_or[30], "scaled cross vector not in range")
  `PFN_ASSERT_SAME(a_quo_bound, state == ST_ACC, quo <= pfn_pkg::OneQ30, "unit component too large")
  `PFN_ASSERT_NEXT(a_load_shows, result_load, out_valid, "loaded result not presented")
  `PFN_ASSERT_SAME(a_pop_idle, job_pop, !qstat.empty, "job taken from empty queue")

endmodule

`default_nettype wire

/* design/polygon_face_normal_core.sv */
// ----------------------------------------------------------------------------
// polygon_face_normal_core
// Face normal of a polygon from a stream of its vertices.
// ----------------------------------------------------------------------------
// Usage: vertices enter on the input channel (in_valid / in_stall) as Q16.16
// coordinates with last_vertex marking the end of the polygon. One request is
// returned on the output channel (out_valid / out_stall) per polygon: the
// average of the Q2.30 unit normals of its fan triangles, or zero with
// too_few_vertices set when fewer than three vertices came in.
// The front takes a vertex whenever the queue is not full and puts triangle
// work into a two-entry queue; the back unit handles one triangle at a time,
// its work set by the 32-step square root and three 31-step divisions, which
// a zero-area one skips. The final average takes three 48-step divisions.
// First and second vertices put no work into the queue unless marked last.
// Reset clears the vertex and triangle counts, the sums and the queue.
// While the receiver stalls, the result holds in the output register; the
// back unit finishes the next polygon and then waits, and the front stalls
// once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_face_normal_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic               last_vertex,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      norm_x,
  output logic signed [31:0]      norm_y,
  output logic signed [31:0]      norm_z,
  output logic                    too_few_vertices
);

  pfn_pkg::queue_stat_t qstat;
  pfn_pkg::job_t        push_job;
  pfn_pkg::job_t        head;
  logic                 job_push;
  logic                 job_pop;

  // vertex intake
  pfn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .last_vertex (last_vertex),
    .qstat       (qstat),
    .job_push    (job_push),
    .job         (push_job)
  );

  // job queue
  pfn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head     (head),
    .qstat    (qstat)
  );

  // normal computation
  pfn_back u_back (
    .clk              (clk),
    .rst              (rst),
    .qstat            (qstat),
    .head             (head),
    .job_pop          (job_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .norm_x           (norm_x),
    .norm_y           (norm_y),
    .norm_z           (norm_z),
    .too_few_vertices (too_few_vertices)
  );

endmodule

`default_nettype wire

/* bench/pfn_normal_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfn_normal_checker
// Watches both channels of the polygon face normal core, keeps its own copy
// of the fan triangulation state, predicts the averaged normal of each
// polygon and compares every returned request field by field.
// ----------------------------------------------------------------------------
module pfn_normal_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               last_vertex,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] norm_x,
  input  logic signed [31:0] norm_y,
  input  logic signed [31:0] norm_z,
  input  logic               too_few_vertices,
  output int                 pending_normals,
  output int                 error_count
);

  localparam longint unsigned UnitQ30 = 64'd1 << 30;
  localparam longint unsigned TopQ31  = 64'd1 << 31;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               few;
  } face_normal_t;

  face_normal_t expected_normals[$];

  // polygon state
  longint first_pt[3];
  longint prev_pt[3];
  longint normal_acc[3];
  int     vertex_cnt;
  int     tri_cnt;

  assign pending_normals = expected_normals.size();

  initial error_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic longint unsigned mag64(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv >>= 2;
    while (bitv != 0) begin
      if (val >= root + bitv) begin
        val  = val - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // add one fan triangle (first, previous, cur) as a unit normal
  task automatic fan_triangle_accumulate(input longint cur[3]);
    longint          d[6];
    longint unsigned m[6];
    longint unsigned peak;
    longint unsigned cm[3];
    bit              cneg[3];
    longint          c[3];
    int              sh;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned u;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      d[i]     = prev_pt[i] - first_pt[i];
      d[3 + i] = cur[i] - first_pt[i];
    end
    for (int i = 0; i < 6; i++) begin
      m[i] = mag64(d[i]);
      if (m[i] > peak) peak = m[i];
    end
    // common truncating shift so all differences fit in 30 bits
    sh = 0;
    while ((peak >> sh) >= UnitQ30) sh++;
    for (int i = 0; i < 6; i++) begin
      d[i] = (d[i] < 0) ? -longint'(m[i] >> sh) : longint'(m[i] >> sh);
    end
    c[0] = d[1] * d[5] - d[2] * d[4];
    c[1] = d[2] * d[3] - d[0] * d[5];
    c[2] = d[0] * d[4] - d[1] * d[3];
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      cneg[i] = c[i] < 0;
      cm[i]   = mag64(c[i]);
      if (cm[i] > peak) peak = cm[i];
    end
    // degenerate triangle only bumps the count
    if (peak != 0) begin
      sh = 0;
      if (peak >= TopQ31) begin
        while ((peak >> sh) >= TopQ31) sh++;
        for (int i = 0; i < 3; i++) cm[i] >>= sh;
      end else begin
        while ((peak << sh) < UnitQ30) sh++;
        for (int i = 0; i < 3; i++) cm[i] <<= sh;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += cm[i] * cm[i];
      len = int_sqrt(sq);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
        u = (cm[i] << 30) / len;
        if (u > UnitQ30) u = UnitQ30;
        normal_acc[i] += cneg[i] ? -longint'(u) : longint'(u);
      end
    end
    tri_cnt++;
  endtask

  task automatic clear_polygon();
    for (int i = 0; i < 3; i++) begin
      first_pt[i]   = 0;
      prev_pt[i]    = 0;
      normal_acc[i] = 0;
    end
    vertex_cnt = 0;
    tri_cnt    = 0;
  endtask

  // one accepted vertex request
  task automatic take_vertex(input logic signed [31:0] px, py, pz, input logic fin);
    longint       p[3];
    face_normal_t res;
    longint       q[3];
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    if (vertex_cnt < int'(pfn_pkg::MaxPolyVertices)) begin
      if (vertex_cnt == 0) first_pt = p;
      else if (vertex_cnt >= 2) fan_triangle_accumulate(p);
      prev_pt = p;
      vertex_cnt++;
    end
    if (fin) begin
      if (tri_cnt == 0) begin
        res = '{x: '0, y: '0, z: '0, few: 1'b1};
      end else begin
        for (int i = 0; i < 3; i++) begin
          q[i] = longint'(mag64(normal_acc[i]) / longint'(tri_cnt));
          if (normal_acc[i] < 0) q[i] = -q[i];
        end
        res = '{x: q[0][31:0], y: q[1][31:0], z: q[2][31:0], few: 1'b0};
      end
      expected_normals.push_back(res);
      clear_polygon();
    end
  endtask

  // channel monitor
  always @(posedge clk) begin
    face_normal_t exp_n;
    if (rst) begin
      clear_polygon();
      expected_normals.delete();
    end else begin
      if (in_valid && !in_stall) take_vertex(pos_x, pos_y, pos_z, last_vertex);
      if (out_valid && !out_stall) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("normal request with none expected");
        end else begin
          exp_n = expected_normals.pop_front();
          if (norm_x !== exp_n.x)
            report_mismatch($sformatf("norm_x got %0d want %0d", norm_x, exp_n.x));
          if (norm_y !== exp_n.y)
            report_mismatch($sformatf("norm_y got %0d want %0d", norm_y, exp_n.y));
          if (norm_z !== exp_n.z)
            report_mismatch($sformatf("norm_z got %0d want %0d", norm_z, exp_n.z));
          if (too_few_vertices !== exp_n.few)
            report_mismatch($sformatf("too_few_vertices got %b want %b",
                                      too_few_vertices, exp_n.few));
        end
      end
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the polygon face normal core: directed polygons covering
// short, degenerate and extreme-coordinate cases, then random polygons with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumItems   = 1050;
  localparam int QuietAfter = 900;
  localparam int IdleLimit  = 20000;
  localparam int HoldCycles = 3000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               last_vertex;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic signed [31:0] norm_z;
  logic               too_few_vertices;

  int pending_normals;
  int error_count;
  int sent_items;
  bit quiet;
  bit hold_req;
  int idle_cycles;

  polygon_face_normal_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .pos_z            (pos_z),
    .last_vertex      (last_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .norm_x           (norm_x),
    .norm_y           (norm_y),
    .norm_z           (norm_z),
    .too_few_vertices (too_few_vertices)
  );

  pfn_normal_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .pos_z            (pos_z),
    .last_vertex      (last_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .norm_x           (norm_x),
    .norm_y           (norm_y),
    .norm_z           (norm_z),
    .too_few_vertices (too_few_vertices),
    .pending_normals  (pending_normals),
    .error_count      (error_count)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    int hold;
    out_stall = 1'b0;
    burst     = 0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold     = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst     = $urandom_range(1, 8);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("polygon_face_normal_core regression: fail");
        $finish;
      end
    end
  end

  // one vertex request; called at a falling edge, returns at a falling edge
  task automatic send_vertex(input logic signed [31:0] x, y, z, input logic fin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    pos_x       = x;
    pos_y       = y;
    pos_z       = z;
    last_vertex = fin;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(input int range_sel);
    case (range_sel)
      0:       return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      1:       return $signed($urandom) >>> $urandom_range(1, 12);
      default: return $signed($urandom);
    endcase
  endfunction

  // random polygon; some vertices repeat earlier ones to form flat triangles
  task automatic send_polygon(input int count, input int range_sel);
    logic signed [31:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        // repeat the previous vertex
      end else begin
        x = rand_coord(range_sel);
        y = rand_coord(range_sel);
        z = rand_coord(range_sel);
      end
      send_vertex(x, y, z, i == count - 1);
    end
  endtask

  initial begin
    int n;
    rst         = 1'b1;
    in_valid    = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    last_vertex = 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    sent_items  = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // too few vertices: one, then two
    send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1);
    send_vertex(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_vertex(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, 1'b1);
    // unit triangle in the xy plane
    send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_vertex(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_vertex(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, 1'b1);
    // square, two fan triangles
    send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000, 1'b0);
    send_vertex(32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
    send_vertex(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, 1'b1);
    // zero-area triangle from three equal points
    repeat (2) send_vertex(32'sh1234_5678, -32'sh0abc_def0, 32'sh7fff_ffff, 1'b0);
    send_vertex(32'sh1234_5678, -32'sh0abc_def0, 32'sh7fff_ffff, 1'b1);
    // extreme coordinates, huge differences force the common shift
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    // collinear points and smallest steps
    send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_vertex(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001, 1'b0);
    send_vertex(32'sh0000_0002, 32'sh0000_0002, 32'sh0000_0002, 1'b0);
    send_vertex(-32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0000, 1'b1);

    // long receiver hold-off while vertices keep coming
    hold_req = 1'b1;

    // random polygons, mostly well formed
    while (sent_items < NumItems) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 9);
      if (sent_items > QuietAfter) quiet = 1'b1;
      send_polygon(n, $urandom_range(0, 2));
    end
    in_valid    = 1'b0;
    last_vertex = 1'b0;

    wait (pending_normals == 0);
    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("polygon_face_normal_core regression: pass");
    end else begin
      $display("polygon_face_normal_core regression: fail");
    end
    $finish;
  end

endmodule
